FILE: hw/rtl/glk_pkg.sv
`default_nettype none

package glk_pkg;

    localparam logic [1:0] KIND_METRIC = 2'd0;
    localparam logic [1:0] KIND_KERN   = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;
    localparam logic [1:0] KIND_CHAR   = 2'd3;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    localparam logic [14:0] LINE_ADVANCE_RESET = 15'd1024;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef logic signed [23:0] pos_t;
    typedef logic signed [26:0] wide_t;
    typedef logic signed [15:0] metric_val_t;

    localparam wide_t POS_MAX_W = 27'sd8388607;
    localparam wide_t POS_MIN_W = -27'sd8388608;

    typedef struct packed {
        metric_val_t adv;
        metric_val_t bx;
        metric_val_t by;
        metric_val_t h;
    } metric_t;

    typedef struct packed {
        logic        vld;
        metric_val_t value;
    } kern_entry_t;

    typedef struct packed {
        logic [7:0] code;
        pos_t       x;
    } buf_entry_t;

    typedef struct packed {
        logic        glyph_valid;
        logic [7:0]  code;
        pos_t        x;
        pos_t        y;
        logic        last;
        logic [15:0] count;
        logic        ovf;
    } result_t;

    function automatic pos_t sat24(input wide_t v);
        pos_t r;
        if (v > POS_MAX_W)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < POS_MIN_W)
        begin
            r = -24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/glk_if.sv
`default_nettype none

interface glk_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         char_code;
    logic [7:0]         right_code;
    logic signed [15:0] advance;
    logic signed [15:0] glyph_left;
    logic signed [15:0] glyph_top;
    logic signed [15:0] glyph_height;
    logic signed [15:0] kern_value;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic               centered;
    logic               end_of_text;

    modport source (
        output valid, kind, char_code, right_code, advance, glyph_left, glyph_top,
               glyph_height, kern_value, start_x, start_y, centered, end_of_text,
        input  ready
    );
    modport sink (
        input  valid, kind, char_code, right_code, advance, glyph_left, glyph_top,
               glyph_height, kern_value, start_x, start_y, centered, end_of_text,
        output ready
    );
endinterface

interface glk_result_if;
    logic               valid;
    logic               ready;
    logic               glyph_valid;
    logic [7:0]         glyph_code;
    logic signed [23:0] glyph_x;
    logic signed [23:0] glyph_y;
    logic               last_of_text;
    logic [15:0]        glyph_count;
    logic               line_overflow;

    modport source (
        output valid, glyph_valid, glyph_code, glyph_x, glyph_y, last_of_text,
               glyph_count, line_overflow,
        input  ready
    );
    modport sink (
        input  valid, glyph_valid, glyph_code, glyph_x, glyph_y, last_of_text,
               glyph_count, line_overflow,
        output ready
    );
endinterface

interface glk_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/glk_metric_mem.sv
`default_nettype none

module glk_metric_mem #(
    parameter int CODE_BITS = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 we,
    input  wire logic [CODE_BITS-1:0] waddr,
    input  wire glk_pkg::metric_t     wdata,
    input  wire logic [CODE_BITS-1:0] raddr,
    output glk_pkg::metric_t          rdata
);
    import glk_pkg::*;

    localparam int DEPTH = 1 << CODE_BITS;

    metric_t          metric_mem [DEPTH];
    metric_t          q_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            metric_mem[waddr] <= wdata;
        end
        q_reg <= metric_mem[raddr];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (we)
        begin
            vld_next[waddr] = 1'b1;
        end
    end

    // entries never loaded read as zero metrics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            q_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = q_vld_reg ? q_reg : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/glk_kern_mem.sv
`default_nettype none

module glk_kern_mem #(
    parameter int CODE_BITS = 7
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   we,
    input  wire logic [2*CODE_BITS-1:0] waddr,
    input  wire glk_pkg::kern_entry_t   wdata,
    input  wire logic [2*CODE_BITS-1:0] raddr,
    output glk_pkg::kern_entry_t        rdata,
    output logic                        busy
);
    import glk_pkg::*;

    localparam int AW    = 2 * CODE_BITS;
    localparam int DEPTH = 1 << AW;

    kern_entry_t   kern_mem [DEPTH];
    kern_entry_t   q_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          busy_reg;
    logic          busy_next;

    // one entry cleared per cycle after reset
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            kern_mem[clr_cnt_reg] <= '0;
        end
        else if (we)
        begin
            kern_mem[waddr] <= wdata;
        end
        q_reg <= kern_mem[raddr];
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == '1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    assign rdata = q_reg;
    assign busy  = busy_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/glyph_layout_kerning.sv
// Glyph placer with kerning, 18.6 fixed point positions. Items are taken one at a time:
// a metric load is written at once, a kern load is read then written if still unset
// (first load of a pair wins; dropped when a code lies outside the table), a character
// passes through metric and kern memory read, position and pen update; an end record
// follows when the item that ends a string emits no glyph. In centered mode a line is
// held in a buffer of LINE_MAX entries and released at newline or end of text through
// S_FRD, S_FMET and S_FOUT per glyph, each re-reading the metric table for its y; a
// stalled result output holds any cycle that must emit. After reset the kern map is
// cleared one entry per cycle, 2^(2*CODE_BITS) entries (16384 at CODE_BITS 7), while no
// item is taken; the line_advance register can be written at any time the block is idle.
`default_nettype none

module glyph_layout_kerning #(
    parameter int LINE_MAX  = 63,
    parameter int CODE_BITS = 7
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    glk_cfg_if.sink     cfg,
    glk_item_if.sink    items,
    glk_result_if.source results
);
    import glk_pkg::*;

    localparam int IDX_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int FILL_W = $clog2(LINE_MAX + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LINE_MAX);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_KWR  = 10'b0000000010,
        S_CHR  = 10'b0000000100,
        S_GLY  = 10'b0000001000,
        S_NL   = 10'b0000010000,
        S_FIN  = 10'b0000100000,
        S_FRD  = 10'b0001000000,
        S_FMET = 10'b0010000000,
        S_FOUT = 10'b0100000000,
        S_END  = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [14:0]            line_adv_reg, line_adv_next;
    pos_t                   pen_x_reg, pen_x_next;
    pos_t                   pen_y_reg, pen_y_next;
    pos_t                   origin_reg, origin_next;
    pos_t                   lw_reg, lw_next;
    logic                   center_reg, center_next;
    logic                   overflow_reg, overflow_next;
    logic [CODE_BITS-1:0]   prev_reg, prev_next;
    logic [15:0]            placed_reg, placed_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [FILL_W-1:0]      flush_idx_reg, flush_idx_next;
    logic                   emitted_reg, emitted_next;
    logic [7:0]             code_reg, code_next;
    logic                   eot_reg, eot_next;
    metric_val_t            kern_val_reg, kern_val_next;
    logic [2*CODE_BITS-1:0] kern_addr_reg, kern_addr_next;
    pos_t                   x_reg, x_next;
    pos_t                   y_reg, y_next;
    logic signed [16:0]     step_reg, step_next;
    logic signed [17:0]     ks_reg, ks_next;
    logic signed [24:0]     base_reg, base_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    buf_entry_t             buf_q_reg;

    buf_entry_t             line_buf [LINE_MAX];

    metric_t                md;
    kern_entry_t            kd;
    logic                   kern_busy;
    logic                   kern_we;
    logic                   metric_we;
    logic [CODE_BITS-1:0]   metric_raddr;
    logic [2*CODE_BITS-1:0] kern_raddr;
    logic                   accept;
    logic                   code_ok;
    logic                   right_ok;
    logic                   out_free;
    logic                   buf_we;
    logic                   flush_last;
    metric_val_t            k16;
    logic signed [16:0]     step17;
    pos_t                   y_calc;
    logic [15:0]            placed_inc;

    assign accept   = items.valid && items.ready;
    assign code_ok  = (items.char_code >> CODE_BITS) == 8'd0;
    assign right_ok = (items.right_code >> CODE_BITS) == 8'd0;
    assign out_free = !out_valid_reg || results.ready;

    assign items.ready = (state_reg == S_IDLE) && !kern_busy;
    assign cfg.ready   = 1'b1;

    // the flushed glyph's metrics must stay on the read port while its result waits
    assign metric_we    = accept && (items.kind == KIND_METRIC) && code_ok;
    assign metric_raddr = ((state_reg == S_FMET) || (state_reg == S_FOUT))
                        ? buf_q_reg.code[CODE_BITS-1:0]
                        : items.char_code[CODE_BITS-1:0];
    assign kern_raddr   = (items.kind == KIND_KERN)
                        ? {items.char_code[CODE_BITS-1:0], items.right_code[CODE_BITS-1:0]}
                        : {prev_reg, items.char_code[CODE_BITS-1:0]};
    assign kern_we      = (state_reg == S_KWR) && !kd.vld;

    glk_metric_mem #(
        .CODE_BITS (CODE_BITS)
    ) u_metric (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (metric_we),
        .waddr (items.char_code[CODE_BITS-1:0]),
        .wdata ({items.advance, items.glyph_left, items.glyph_top, items.glyph_height}),
        .raddr (metric_raddr),
        .rdata (md)
    );

    glk_kern_mem #(
        .CODE_BITS (CODE_BITS)
    ) u_kern (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (kern_we),
        .waddr (kern_addr_reg),
        .wdata ({1'b1, kern_val_reg}),
        .raddr (kern_raddr),
        .rdata (kd),
        .busy  (kern_busy)
    );

    // line buffer, written at the fill point, read during the flush
    assign buf_we = (state_reg == S_GLY) && center_reg && (fill_reg != FILL_FULL);

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            line_buf[fill_reg[IDX_W-1:0]] <= '{code: code_reg, x: x_reg};
        end
        buf_q_reg <= line_buf[flush_idx_reg[IDX_W-1:0]];
    end

    // kern applies only after a previous code
    assign k16        = ((prev_reg != '0) && kd.vld) ? kd.value : '0;
    assign step17     = 17'(wide_t'(md.adv) - wide_t'(md.bx));
    assign y_calc     = sat24(wide_t'(pen_y_reg) - (wide_t'(md.h) - wide_t'(md.by)));
    assign placed_inc = (placed_reg == COUNT_MAX) ? placed_reg : placed_reg + 16'd1;
    assign flush_last = (flush_idx_reg + FILL_W'(1)) == fill_reg;

    always_comb
    begin
        state_next     = state_reg;
        line_adv_next  = line_adv_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        origin_next    = origin_reg;
        lw_next        = lw_reg;
        center_next    = center_reg;
        overflow_next  = overflow_reg;
        prev_next      = prev_reg;
        placed_next    = placed_reg;
        fill_next      = fill_reg;
        flush_idx_next = flush_idx_reg;
        emitted_next   = emitted_reg;
        code_next      = code_reg;
        eot_next       = eot_reg;
        kern_val_next  = kern_val_reg;
        kern_addr_next = kern_addr_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        step_next      = step_reg;
        ks_next        = ks_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_next       = out_reg;

        if (cfg.valid)
        begin
            line_adv_next = cfg.data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    code_next      = items.char_code;
                    eot_next       = items.end_of_text;
                    emitted_next   = 1'b0;
                    kern_val_next  = items.kern_value;
                    kern_addr_next = {items.char_code[CODE_BITS-1:0],
                                      items.right_code[CODE_BITS-1:0]};
                    unique case (items.kind)
                        KIND_METRIC:
                        begin
                            state_next = S_IDLE;
                        end
                        KIND_KERN:
                        begin
                            if (code_ok && right_ok)
                            begin
                                state_next = S_KWR;
                            end
                        end
                        KIND_START:
                        begin
                            center_next   = items.centered;
                            origin_next   = items.start_x;
                            pen_y_next    = items.start_y;
                            pen_x_next    = items.centered ? '0 : items.start_x;
                            prev_next     = '0;
                            placed_next   = '0;
                            lw_next       = '0;
                            fill_next     = '0;
                            overflow_next = 1'b0;
                            state_next    = items.end_of_text ? S_FIN : S_IDLE;
                        end
                        KIND_CHAR:
                        begin
                            state_next = S_CHR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_KWR:
            begin
                state_next = S_IDLE;
            end

            S_CHR:
            begin
                priority if (code_reg == CHAR_NL)
                begin
                    if (center_reg && (fill_reg != '0))
                    begin
                        flush_idx_next = '0;
                        state_next     = S_FRD;
                    end
                    else
                    begin
                        state_next = S_NL;
                    end
                end
                else if (code_reg == CHAR_SPACE)
                begin
                    pen_x_next = sat24(wide_t'(pen_x_reg) + wide_t'(md.adv) + wide_t'(k16));
                    lw_next    = sat24(wide_t'(lw_reg) + wide_t'(step17) + wide_t'(k16));
                    prev_next  = code_reg[CODE_BITS-1:0];
                    state_next = S_FIN;
                end
                else if ((code_reg > CHAR_SPACE) && (code_reg <= CHAR_TILDE))
                begin
                    x_next     = sat24(wide_t'(pen_x_reg) + wide_t'(k16));
                    y_next     = y_calc;
                    step_next  = step17;
                    ks_next    = 18'(wide_t'(step17) + wide_t'(k16));
                    state_next = S_GLY;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_GLY:
            begin
                if (center_reg || out_free)
                begin
                    if (center_reg)
                    begin
                        if (fill_reg != FILL_FULL)
                        begin
                            fill_next = fill_reg + FILL_W'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{glyph_valid: 1'b1, code: code_reg, x: x_reg,
                                           y: y_reg, last: eot_reg,
                                           count: eot_reg ? placed_inc : 16'd0,
                                           ovf: overflow_reg};
                        placed_next    = placed_inc;
                        emitted_next   = 1'b1;
                    end
                    pen_x_next = sat24(wide_t'(x_reg) + wide_t'(step_reg));
                    lw_next    = sat24(wide_t'(lw_reg) + wide_t'(ks_reg));
                    prev_next  = code_reg[CODE_BITS-1:0];
                    state_next = S_FIN;
                end
            end

            S_NL:
            begin
                pen_y_next = sat24(wide_t'(pen_y_reg) - wide_t'(line_adv_reg));
                pen_x_next = center_reg ? '0 : origin_reg;
                lw_next    = '0;
                prev_next  = '0;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                priority if (!eot_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (center_reg && (fill_reg != '0))
                begin
                    flush_idx_next = '0;
                    state_next     = S_FRD;
                end
                else if (!emitted_reg)
                begin
                    state_next = S_END;
                end
                else
                begin
                    placed_next   = '0;
                    overflow_next = 1'b0;
                    prev_next     = '0;
                    lw_next       = '0;
                    fill_next     = '0;
                    if (center_reg)
                    begin
                        pen_x_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            S_FRD:
            begin
                // line start minus half the measured width, rounded down
                base_next  = 25'(wide_t'(origin_reg) - wide_t'(lw_reg >>> 1));
                state_next = S_FMET;
            end

            S_FMET:
            begin
                x_next     = sat24(wide_t'(base_reg) + wide_t'(buf_q_reg.x));
                state_next = S_FOUT;
            end

            S_FOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{glyph_valid: 1'b1, code: buf_q_reg.code, x: x_reg,
                                       y: y_calc, last: eot_reg && flush_last,
                                       count: (eot_reg && flush_last) ? placed_inc : 16'd0,
                                       ovf: overflow_reg};
                    placed_next    = placed_inc;
                    emitted_next   = 1'b1;
                    flush_idx_next = flush_idx_reg + FILL_W'(1);
                    if (flush_last)
                    begin
                        fill_next  = '0;
                        state_next = (code_reg == CHAR_NL) ? S_NL : S_FIN;
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end

            S_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{glyph_valid: 1'b0, code: 8'd0, x: '0, y: '0,
                                       last: 1'b1, count: placed_reg, ovf: overflow_reg};
                    placed_next    = '0;
                    overflow_next  = 1'b0;
                    prev_next      = '0;
                    lw_next        = '0;
                    fill_next      = '0;
                    if (center_reg)
                    begin
                        pen_x_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            line_adv_reg  <= LINE_ADVANCE_RESET;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            origin_reg    <= '0;
            lw_reg        <= '0;
            center_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            prev_reg      <= '0;
            placed_reg    <= '0;
            fill_reg      <= '0;
            flush_idx_reg <= '0;
            emitted_reg   <= 1'b0;
            eot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_adv_reg  <= line_adv_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            origin_reg    <= origin_next;
            lw_reg        <= lw_next;
            center_reg    <= center_next;
            overflow_reg  <= overflow_next;
            prev_reg      <= prev_next;
            placed_reg    <= placed_next;
            fill_reg      <= fill_next;
            flush_idx_reg <= flush_idx_next;
            emitted_reg   <= emitted_next;
            eot_reg       <= eot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        kern_val_reg  <= kern_val_next;
        kern_addr_reg <= kern_addr_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        step_reg      <= step_next;
        ks_reg        <= ks_next;
        base_reg      <= base_next;
        out_reg       <= out_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.glyph_valid   = out_reg.glyph_valid;
    assign results.glyph_code    = out_reg.code;
    assign results.glyph_x       = out_reg.x;
    assign results.glyph_y       = out_reg.y;
    assign results.last_of_text  = out_reg.last;
    assign results.glyph_count   = out_reg.count;
    assign results.line_overflow = out_reg.ovf;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("line buffer fill beyond its depth");

    a_fill_center: assert property (@(posedge clk) disable iff (!rst_n)
        !center_reg |-> fill_reg == '0)
        else $error("line buffer in use outside centered mode");

    a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> out_reg.count == 16'd0)
        else $error("glyph count on a result that does not end the string");

    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        kern_busy |-> !items.ready)
        else $error("item taken during kern map clearing");

endmodule

`default_nettype wire
